/* src/http_chunked_body_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define CBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbd assertion failed");

// next-cycle implication
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbd assertion failed");

`endif

/* src/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_TRAIL  = 3'd2,
    PH_REST   = 3'd3,
    PH_DATA   = 3'd4,
    PH_SKIP   = 3'd5
  } phase_e;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] WS_MAX    = 8'h20;
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  localparam int unsigned SizeW = 32;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(logic [7:0] b);
    hex_t r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = b[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/http_chunked_body_decoder_unit.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Strips chunk framing from an HTTP/1.1 chunked body, one byte per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_byte_i) takes one raw body byte per
// item. Output channel (out_valid_o/out_ready_i) gives payload bytes with
// kind_o = 0, or an end-of-body marker with kind_o = 1; bad_size_o marks a
// marker caused by a malformed size line. Valid nonzero size lines, blank
// lines and the two bytes after each payload produce no output item.
// An accepted byte is held in the input register, then decoded into the
// result register. Throughput: one byte per cycle while the receiver does
// not stall, set by the single decode stage that updates the parser state
// for each decoded byte.
// Reset clears the parser to the start of a size line and empties both
// registers. When the receiver stalls, the result register holds and the
// input register fills; in_ready_o drops once both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_unit #(
  parameter int unsigned MAX_SIZE_DIGITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            kind_o,
  output logic            bad_size_o
);
  import cbd_pkg::*;

  localparam int unsigned CntW = (MAX_SIZE_DIGITS > 1) ? $clog2(MAX_SIZE_DIGITS) : 1;
  localparam logic [CntW:0] MaxDigits = (CntW + 1)'(MAX_SIZE_DIGITS);

  typedef struct packed {
    phase_e            phase;
    logic [SizeW-1:0]  accum;
    logic [CntW-1:0]   cnt;
    logic              invalid;
  } line_t;

  function automatic line_t line_step(line_t s, logic [7:0] b);
    line_t       r;
    logic        ws;
    hex_t        hv;
    logic [CntW:0] nxt;
    r   = s;
    ws  = (b <= WS_MAX);
    hv  = hex_value(b);
    nxt = {1'b0, s.cnt} + {{CntW{1'b0}}, 1'b1};
    unique case (s.phase)
      PH_DIGITS: begin
        if (hv.ok) begin
          if (nxt >= MaxDigits) begin
            r.invalid = 1'b1;
            r.phase   = PH_REST;
          end else begin
            r.cnt   = nxt[CntW-1:0];
            r.accum = {s.accum[SizeW-5:0], hv.val};
          end
        end else if (b == CHAR_SEMI) begin
          r.phase = PH_REST;
        end else if (ws) begin
          r.phase = PH_TRAIL;
        end else begin
          r.invalid = 1'b1;
          r.phase   = PH_REST;
        end
      end
      PH_TRAIL: begin
        if (!ws) begin
          r.invalid = 1'b1;
          r.phase   = PH_REST;
        end
      end
      PH_REST: begin
      end
      default: begin
        r.phase = PH_LEAD;
        if (!ws) begin
          if (hv.ok) begin
            r.phase = PH_DIGITS;
            r.cnt   = '0;
            r.accum = {{(SizeW-4){1'b0}}, hv.val};
          end else begin
            r.invalid = 1'b1;
            r.phase   = PH_REST;
          end
        end
      end
    endcase
    return r;
  endfunction

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  line_t            line_q, line_d;
  logic             pend_q, pend_d;
  logic [SizeW-1:0] data_left_q, data_left_d;
  logic [1:0]       skip_q, skip_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             kind_q, bad_q;

  logic  go;
  logic  fire;
  logic  line_end;
  logic  res_valid, res_kind, res_bad;
  logic [7:0] res_byte;
  line_t ln;

  assign go         = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && go;
  assign in_ready_o = !in_valid_q || go;
  assign line_end   = pend_q && (in_byte_q == CHAR_LF);

  always_comb begin
    line_d      = line_q;
    pend_d      = pend_q;
    data_left_d = data_left_q;
    skip_d      = skip_q;
    ln          = line_q;
    unique case (line_q.phase)
      PH_DATA: begin
        data_left_d = data_left_q - SizeW'(1);
        if (data_left_q == SizeW'(1)) begin
          line_d.phase = PH_SKIP;
          skip_d       = SKIP_BYTES;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - 2'd1;
        if (skip_q == 2'd1) begin
          line_d.phase = PH_LEAD;
        end
      end
      default: begin
        if (line_end) begin
          line_d = '{phase: PH_LEAD, accum: '0, cnt: '0, invalid: 1'b0};
          pend_d = 1'b0;
          if (line_q.phase != PH_LEAD && !line_q.invalid && line_q.accum != '0) begin
            data_left_d  = line_q.accum;
            line_d.phase = PH_DATA;
          end
        end else begin
          if (pend_q) begin
            ln = line_step(ln, CHAR_CR);
          end
          if (in_byte_q != CHAR_CR) begin
            ln = line_step(ln, in_byte_q);
          end
          pend_d = (in_byte_q == CHAR_CR);
          line_d = ln;
        end
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res_byte  = '0;
    res_kind  = 1'b0;
    res_bad   = 1'b0;
    unique case (line_q.phase)
      PH_DATA: begin
        res_valid = 1'b1;
        res_byte  = in_byte_q;
      end
      PH_SKIP: begin
      end
      default: begin
        if (line_end && line_q.phase != PH_LEAD &&
            (line_q.invalid || line_q.accum == '0)) begin
          res_valid = 1'b1;
          res_kind  = 1'b1;
          res_bad   = line_q.invalid;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      line_q      <= '{phase: PH_LEAD, accum: '0, cnt: '0, invalid: 1'b0};
      pend_q      <= 1'b0;
      data_left_q <= '0;
      skip_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        line_q      <= line_d;
        pend_q      <= pend_d;
        data_left_q <= data_left_d;
        skip_q      <= skip_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (fire && res_valid) begin
      out_byte_q <= res_byte;
      kind_q     <= res_kind;
      bad_q      <= res_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = kind_q;
  assign bad_size_o  = bad_q;

endmodule

`default_nettype wire

/* src/cbd_checker.sv */
// ----------------------------------------------------------------------------
// cbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_unit_assert.svh"

module cbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       kind_o,
  input wire logic       bad_size_o
);

  `CBD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_byte_o) && $stable(kind_o) && $stable(bad_size_o))
  `CBD_ASSERT_NOW(a_bad_only_marker, out_valid_o && !kind_o, !bad_size_o)
  `CBD_ASSERT_NOW(a_marker_zero, out_valid_o && kind_o, out_byte_o == 8'h00)
  `CBD_ASSERT_NOW(a_rise_after_ready, $rose(out_valid_o), $past(in_ready_o))

endmodule

bind http_chunked_body_decoder_unit cbd_checker u_cbd_checker (.*);

`default_nettype wire

/* verif/http_chunked_body_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit_tb
// Self-checking bench for the chunked body decoder. Named tests push raw body
// bytes through the valid/ready input: a short directed set for payload byte
// extremes, whitespace, extensions and malformed size lines, a receiver hold
// that backs the block up, then a long random stream of mostly well-formed
// chunks mixed with bad lines and noise. A bit-accurate decoder in the bench
// predicts every payload byte and end marker, and a checker compares each
// output item field by field in order. Sender bursts and receiver stalls are
// randomized; a watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  localparam int MaxSizeDigits = 8;
  localparam int StallLimit    = 4000;
  localparam int HoldCycles    = 200;
  localparam int RandomBytes   = 820;

  typedef struct packed {
    logic [7:0] data;
    logic       marker;
    logic       bad;
  } body_item_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       kind_o;
  logic       bad_size_o;

  http_chunked_body_decoder_unit #(
    .MAX_SIZE_DIGITS(MaxSizeDigits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o),
    .bad_size_o (bad_size_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // decoder state
  phase_e      rx_phase      = PH_LEAD;
  logic [31:0] size_acc      = '0;
  logic [3:0]  digits_minus1 = '0;
  logic        line_bad      = 1'b0;
  logic        cr_held       = 1'b0;
  logic [31:0] payload_left  = '0;
  logic [1:0]  trailer_left  = '0;

  body_item_t body_q[$];
  body_item_t want;
  int         fail_count  = 0;
  int         bytes_sent  = 0;
  int         burst_left  = 0;
  int         gap_max     = 4;
  int         hold_cycles = 0;
  rx_mode_e   ready_mode  = RX_ALWAYS;

  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b0, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b0, 4'(b - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void clear_line();
    rx_phase      = PH_LEAD;
    size_acc      = '0;
    digits_minus1 = '0;
    line_bad      = 1'b0;
    cr_held       = 1'b0;
  endfunction

  function automatic void reject_line();
    line_bad = 1'b1;
    rx_phase = PH_REST;
  endfunction

  function automatic void size_line_char(input logic [7:0] b);
    logic       ws;
    logic [4:0] nib;
    ws  = (b <= WS_MAX);
    nib = nibble_of(b);
    case (rx_phase)
      PH_DIGITS: begin
        if (!nib[4]) begin
          if (32'(digits_minus1) + 1 >= MaxSizeDigits) begin
            reject_line();
          end else begin
            digits_minus1 = digits_minus1 + 4'd1;
            size_acc      = {size_acc[27:0], nib[3:0]};
          end
        end else if (b == CHAR_SEMI) begin
          rx_phase = PH_REST;
        end else if (ws) begin
          rx_phase = PH_TRAIL;
        end else begin
          reject_line();
        end
      end
      PH_TRAIL: begin
        if (!ws) reject_line();
      end
      PH_REST: ;
      default: begin
        if (!ws) begin
          if (!nib[4]) begin
            rx_phase      = PH_DIGITS;
            digits_minus1 = '0;
            size_acc      = {28'd0, nib[3:0]};
          end else begin
            reject_line();
          end
        end
      end
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] b, output logic has, output body_item_t r);
    has = 1'b0;
    r   = '0;
    if (rx_phase == PH_DATA) begin
      has          = 1'b1;
      r.data       = b;
      payload_left = payload_left - 1;
      if (payload_left == 0) begin
        rx_phase     = PH_SKIP;
        trailer_left = SKIP_BYTES;
      end
      return;
    end
    if (rx_phase == PH_SKIP) begin
      trailer_left = trailer_left - 2'd1;
      if (trailer_left == 0) rx_phase = PH_LEAD;
      return;
    end
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CHAR_LF) begin
        if (rx_phase == PH_LEAD) begin
          clear_line();
        end else if (line_bad || size_acc == 0) begin
          has      = 1'b1;
          r.marker = 1'b1;
          r.bad    = line_bad;
          clear_line();
        end else begin
          payload_left = size_acc;
          clear_line();
          rx_phase = PH_DATA;
        end
        return;
      end
      size_line_char(CHAR_CR);
    end
    if (b == CHAR_CR) begin
      cr_held = 1'b1;
      return;
    end
    size_line_char(b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int         gap;
    logic       has;
    body_item_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    decode_byte(b, has, r);
    if (has) body_q.insert(body_q.size(), r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (body_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_hex(input logic [3:0] v);
    if (v < 10) send_byte(8'("0" + v));
    else if ($urandom_range(0, 1) != 0) send_byte(8'("a" + v - 10));
    else send_byte(8'("A" + v - 10));
  endtask

  task automatic send_size(input logic [31:0] size, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) send_hex(4'(size >> (4 * i)));
  endtask

  task automatic send_ws(input int max_len);
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, max_len);
    repeat (n) begin
      b = 8'($urandom_range(0, 32));
      if (b == CHAR_CR || $urandom_range(0, 7) == 0) begin
        send_byte(CHAR_CR);
        b = 8'h20;
      end
      send_byte(b);
    end
  endtask

  task automatic send_line_tail(input int max_len);
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, max_len);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_CR) begin
        send_byte(CHAR_CR);
        b = "q";
      end
      send_byte(b);
    end
  endtask

  task automatic send_line_end();
    case ($urandom_range(0, 2))
      0: ;
      1: send_ws(2);
      default: begin
        send_byte(CHAR_SEMI);
        send_line_tail(6);
      end
    endcase
    send_crlf();
  endtask

  task automatic send_data_chunk();
    int size;
    int need;
    int ndig;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    need = (size > 15) ? 2 : 1;
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(need, MaxSizeDigits) : need;
    send_ws(2);
    send_size(size, ndig);
    send_line_end();
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) != 0) begin
      send_crlf();
    end else begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_zero_line();
    send_ws(2);
    send_size(0, $urandom_range(1, MaxSizeDigits));
    send_line_end();
  endtask

  task automatic send_bad_line();
    logic [7:0] b;
    logic [4:0] nib;
    send_ws(1);
    case ($urandom_range(0, 7))
      0: begin send_byte("+"); send_hex(4'($urandom_range(1, 15))); end
      1: begin send_byte("-"); send_hex(4'($urandom_range(1, 15))); end
      2: begin send_text("0x"); send_hex(4'($urandom_range(1, 15))); end
      3: begin
        send_hex(4'($urandom_range(1, 15)));
        send_byte(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h09);
        send_hex(4'($urandom_range(0, 15)));
      end
      4: begin send_hex(4'($urandom_range(1, 15))); send_byte(8'h20); send_byte(CHAR_SEMI); end
      5: send_byte(CHAR_SEMI);
      6: repeat ($urandom_range(MaxSizeDigits + 1, MaxSizeDigits + 4))
           send_hex(4'($urandom_range(0, 15)));
      default: begin
        b   = 8'($urandom_range(33, 255));
        nib = nibble_of(b);
        if (!nib[4]) b = "~";
        send_byte(b);
      end
    endcase
    send_line_tail(6);
    send_crlf();
  endtask

  task automatic send_noise_line();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_CR || b == CHAR_SEMI) b = "z";
      send_byte(b);
    end
    send_byte("z");
    send_crlf();
  endtask

  task automatic test_basic_chunk();
    send_text("2");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_crlf();
    send_text("0");
    send_crlf();
  endtask

  task automatic test_line_whitespace();
    send_byte(8'h20);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(8'h00);
    send_text("00000003;x=1");
    send_byte(CHAR_CR);
    send_byte(8'h20);
    send_crlf();
    send_text("a");
    send_crlf();
    send_text("zz");
    send_crlf();
  endtask

  task automatic test_malformed_sizes();
    send_text("+1");
    send_crlf();
    send_text("0x1");
    send_crlf();
    send_text("1 2");
    send_crlf();
    send_text("4 ;");
    send_crlf();
    send_text(";e");
    send_crlf();
    send_text("000000001");
    send_crlf();
  endtask

  task automatic test_receiver_hold();
    wait_drained();
    ready_mode  = RX_ALWAYS;
    gap_max     = 0;
    hold_cycles = HoldCycles;
    send_text("30");
    send_crlf();
    repeat (48) send_byte(8'($urandom_range(0, 255)));
    send_crlf();
    wait_drained();
  endtask

  task automatic test_random_stream();
    int stop_at;
    int lines;
    int pick;
    stop_at = bytes_sent + RandomBytes;
    lines   = 0;
    while (bytes_sent < stop_at) begin
      if (lines % 12 == 0) begin
        ready_mode = rx_mode_e'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 3;
          default: gap_max = 12;
        endcase
      end
      lines++;
      pick = $urandom_range(0, 99);
      if (pick < 55) send_data_chunk();
      else if (pick < 65) send_zero_line();
      else if (pick < 71) begin send_ws(2); send_crlf(); end
      else if (pick < 90) send_bad_line();
      else send_noise_line();
    end
  endtask

  initial begin : receiver
    int tick;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        case (ready_mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
          default:   out_ready_i <= ((tick % 11) < 6);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (body_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual byte %h kind %b bad %b",
                 $time, out_byte_o, kind_o, bad_size_o);
        fail_count++;
      end else begin
        want = body_q.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          fail_count++;
        end
        if (kind_o !== want.marker) begin
          $display("%0t: kind expected %b actual %b", $time, want.marker, kind_o);
          fail_count++;
        end
        if (bad_size_o !== want.bad) begin
          $display("%0t: bad_size expected %b actual %b", $time, want.bad, bad_size_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("http_chunked_body_decoder_unit_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_chunk();
    test_line_whitespace();
    test_malformed_sizes();
    test_receiver_hold();
    test_random_stream();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (body_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived, first byte %h kind %b bad %b",
               $time, body_q.size(), body_q[0].data, body_q[0].marker, body_q[0].bad);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("http_chunked_body_decoder_unit_tb OK");
    end else begin
      $display("http_chunked_body_decoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
